### rtl/core/hcp_pkg.sv
// ----------------------------------------------------------------------------
// hcp_pkg
// Shared types, constants and helpers for the hex colour command parser.
// ----------------------------------------------------------------------------
package hcp_pkg;

	localparam logic [7:0] FRAME_START = 8'h23;
	localparam logic [7:0] FRAME_END   = 8'h0D;
	localparam logic [2:0] LAST_POS    = 3'd7;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_DONE = 2'd2
	} status_t;

	typedef struct packed {
		logic        is_digit;
		logic [3:0]  nibble;
	} hex_t;

	typedef struct packed {
		logic [2:0]  pos;
		logic [23:0] acc;
		logic [23:0] colour;
		status_t     status;
	} step_t;

	// Decodes one ASCII character into a hex nibble, flagging non-digits.
	function automatic hex_t hex_decode(input logic [7:0] ch);
		hex_t res;
		res.is_digit = 1'b1;
		res.nibble   = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			res.nibble = ch[3:0];
		end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
			res.nibble = ch[3:0] + 4'd9;
		end else begin
			res.is_digit = 1'b0;
		end
		return res;
	endfunction

endpackage

### rtl/core/hcp_step.sv
// ----------------------------------------------------------------------------
// hcp_step
// Frame checker: computes the next frame state and status for one byte.
// ----------------------------------------------------------------------------
module hcp_step import hcp_pkg::*; (
	input  logic [2:0]  pos,
	input  logic [23:0] acc,
	input  logic [23:0] colour,
	input  logic [7:0]  rx_byte,
	output step_t       next
);

	hex_t hex;
	logic ok;

	assign hex = hex_decode(rx_byte);

	always_comb begin
		if (pos == 3'd0) begin
			ok = (rx_byte == FRAME_START);
		end else if (pos == LAST_POS) begin
			ok = (rx_byte == FRAME_END);
		end else begin
			ok = hex.is_digit;
		end

		next.pos    = 3'd0;
		next.acc    = 24'd0;
		next.colour = colour;
		next.status = ST_OK;
		if (!ok) begin
			next.status = ST_BAD;
		end else if (pos == LAST_POS) begin
			next.colour = acc;
			next.status = ST_DONE;
		end else begin
			// The start marker leaves the accumulator alone; digits shift in.
			next.acc = (pos == 3'd0) ? acc : {acc[19:0], hex.nibble};
			next.pos = pos + 3'd1;
		end
	end

endmodule

### rtl/core/hex_colour_command_parser.sv
// ----------------------------------------------------------------------------
// hex_colour_command_parser
// Parses "#RRGGBB\r" frames from a byte stream and drives the displayed colour.
// ----------------------------------------------------------------------------
// Each received word is one character. The block echoes every word and reports
// a status with it: byte accepted, bad format (the frame is dropped and parsing
// restarts at the '#'), or colour complete (the six hex digits, either case,
// have been loaded into the displayed red, green and blue levels). Every result
// word carries the displayed levels as they stand after that character. A word
// passes through an input register and then a result register, from which its
// result is offered. One word is taken every cycle while the output side is not
// stalled; throughput is bounded only by the combinational update of the frame
// position and digit accumulator between the two registers. The input side
// stalls only when the result register is full and itself stalled.
// ----------------------------------------------------------------------------
module hex_colour_command_parser import hcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,

	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] echo_byte,
	output logic [1:0] status,
	output logic [7:0] red_level,
	output logic [7:0] green_level,
	output logic [7:0] blue_level
);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Frame state carried from one character to the next.
	logic [2:0]  pos_q;
	logic [23:0] acc_q;
	logic [23:0] colour_q;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  echo_q;
	status_t     status_q;
	logic [23:0] levels_q;

	step_t       next;
	logic        out_load;
	logic        advance;

	// The result register can take a new word when it is empty or being drained.
	assign out_load = !out_valid_q || !tx_stall;
	assign advance  = valid_s1 && out_load;
	assign rx_stall = valid_s1 && !out_load;

	hcp_step u_step (
		.pos     (pos_q),
		.acc     (acc_q),
		.colour  (colour_q),
		.rx_byte (byte_s1),
		.next    (next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// The frame state moves only when the character's result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			acc_q    <= 24'd0;
			colour_q <= 24'd0;
		end else if (advance) begin
			pos_q    <= next.pos;
			acc_q    <= next.acc;
			colour_q <= next.colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_q   <= byte_s1;
			status_q <= next.status;
			levels_q <= next.colour;
		end
	end

	assign tx_valid    = out_valid_q;
	assign echo_byte   = echo_q;
	assign status      = status_q;
	assign red_level   = levels_q[23:16];
	assign green_level = levels_q[15:8];
	assign blue_level  = levels_q[7:0];

`ifndef SYNTH
	// Status code three is never produced.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> status != 2'd3)
		else $error("status code out of range");

	// At the start of a frame no digits have been collected.
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == 3'd0 || pos_q == 3'd1) |-> acc_q == 24'd0)
		else $error("accumulator not cleared at frame start");

	// The offered levels always match the committed displayed colour.
	a_levels_match: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> {red_level, green_level, blue_level} == colour_q)
		else $error("result levels differ from displayed colour");

	// A stalled input means a word is waiting in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && tx_valid && tx_stall))
		else $error("input stalled without a full, stalled pipeline");
`endif

endmodule

### dv/tb_hex_colour_command_parser.sv
// ----------------------------------------------------------------------------
// tb_hex_colour_command_parser
// Self-checking bench for the "#RRGGBB\r" colour command parser.
// ----------------------------------------------------------------------------
// Characters are pushed into the receive channel one word at a time, with a
// scoreboard that tracks the frame position, the digit accumulator and the
// displayed colour on its own. Every echoed result word is checked field by
// field against the oldest prediction. A short directed sequence covers the
// frame edges and the malformed cases, then mostly well-formed frames with
// random digits follow, mixed with corrupted frames and raw byte noise. Both
// channels idle at random, apart from one window in which neither side idles.
// ----------------------------------------------------------------------------
module tb_hex_colour_command_parser import hcp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TOTAL_WORDS = 1625;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          CALM_START  = 1500;
	localparam int          CALM_END    = 2500;
	localparam int          IDLE_PCT    = 34;
	localparam logic [7:0]  CH_ZERO     = 8'h30;
	localparam logic [7:0]  CH_UPPER_A  = 8'h41;
	localparam logic [7:0]  CH_LOWER_A  = 8'h61;

	// One predicted result word: the echoed character, the status and the
	// displayed colour as RRGGBB after that character.
	typedef struct {
		logic [7:0]  echo;
		status_t     st;
		logic [23:0] colour;
	} colour_result_t;

	// The scoreboard keeps its own copy of the parser state. Each accepted
	// character advances that state and queues the result word it must cause.
	class colour_scoreboard;
		logic [2:0]     frame_pos;
		logic [23:0]    digit_acc;
		logic [23:0]    shown;
		colour_result_t results_due[$];
		int             mismatches;
		int             words_checked;
		int             colours_loaded;
		int             frames_dropped;

		function new();
			frame_pos      = '0;
			digit_acc      = '0;
			shown          = '0;
			mismatches     = 0;
			words_checked  = 0;
			colours_loaded = 0;
			frames_dropped = 0;
		endfunction

		function bit hex_digit(input logic [7:0] ch, output logic [3:0] nib);
			nib = '0;
			if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) begin
				nib = 4'(ch - CH_ZERO);
				return 1'b1;
			end
			if (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd5) begin
				nib = 4'(ch - CH_UPPER_A + 8'd10);
				return 1'b1;
			end
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd5) begin
				nib = 4'(ch - CH_LOWER_A + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_word(input logic [7:0] ch);
			logic [3:0]     nib;
			bit             fits;
			colour_result_t due;
			nib = '0;
			if (frame_pos == 3'd0) begin
				fits = (ch == FRAME_START);
			end else if (frame_pos < LAST_POS) begin
				fits = hex_digit(ch, nib);
			end else begin
				fits = (ch == FRAME_END);
			end
			due.st = ST_OK;
			if (!fits) begin
				frame_pos = '0;
				digit_acc = '0;
				due.st    = ST_BAD;
			end else if (frame_pos == LAST_POS) begin
				shown     = digit_acc;
				frame_pos = '0;
				digit_acc = '0;
				due.st    = ST_DONE;
			end else begin
				if (frame_pos != 3'd0) begin
					digit_acc = {digit_acc[19:0], nib};
				end
				frame_pos = frame_pos + 3'd1;
			end
			due.echo   = ch;
			due.colour = shown;
			results_due.push_back(due);
		endfunction

		function void compare(input string field, input logic [7:0] want,
				input logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input logic [7:0] echo, input logic [1:0] st,
				input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
			colour_result_t due;
			if (results_due.size() == 0) begin
				$display("%0t: result word with nothing due, actual echo %h status %0d",
					$time, echo, st);
				mismatches++;
				return;
			end
			due = results_due.pop_front();
			words_checked++;
			if (due.st == ST_DONE) colours_loaded++;
			if (due.st == ST_BAD) frames_dropped++;
			compare("echo_byte", due.echo, echo);
			compare("status", 8'(due.st), 8'(st));
			compare("red_level", due.colour[23:16], red);
			compare("green_level", due.colour[15:8], green);
			compare("blue_level", due.colour[7:0], blue);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       tx_valid;
	logic       tx_stall;
	logic [7:0] echo_byte;
	logic [1:0] status;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;

	int               cycle_count;
	int               sent_count;
	logic             calm;
	colour_scoreboard sb;

	hex_colour_command_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.echo_byte   (echo_byte),
		.status      (status),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level)
	);

	// Neither side idles inside this window of cycles, so the parser also sees
	// long runs of back-to-back words in both directions.
	assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// The receiver stalls at random; the decision is made at the falling edge
	// so it is stable well before the edge that samples it.
	initial begin
		tx_stall = 1'b0;
	end

	always @(negedge clk) begin
		tx_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	// Both channels are watched at the rising edge. The input side is noted
	// before the output side is checked so a result offered in the same cycle as
	// its input would still find its prediction waiting.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall) begin
				sb.note_word(rx_byte);
			end
			if (tx_valid && !tx_stall) begin
				sb.check_result(echo_byte, status, red_level, green_level, blue_level);
			end
		end
	end

	// Presents one word, optionally after some idle cycles, and holds it until
	// the parser takes it. Called and returning at a falling edge.
	task automatic send_byte(input logic [7:0] ch);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= ch;
		@(posedge clk);
		while (rx_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++) begin
			send_byte(text[i]);
		end
	endtask

	function automatic logic [7:0] digit_char(input logic [3:0] value, input bit lower);
		if (value < 4'd10) begin
			return CH_ZERO + 8'(value);
		end
		return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(value) - 8'd10;
	endfunction

	// Characters that sit just outside the digit ranges, frame markers in the
	// wrong place, or the bytes 0x00 and 0xFF.
	function automatic logic [7:0] near_miss(input int pick);
		case (pick)
			0: begin
				return 8'h2F;
			end
			1: begin
				return 8'h3A;
			end
			2: begin
				return 8'h40;
			end
			3: begin
				return 8'h47;
			end
			4: begin
				return 8'h60;
			end
			5: begin
				return 8'h67;
			end
			6: begin
				return FRAME_START;
			end
			7: begin
				return FRAME_END;
			end
			8: begin
				return 8'h00;
			end
			default: begin
				return 8'hFF;
			end
		endcase
	endfunction

	// Mostly clean frames with random digits and case. About one in six frames
	// has one character replaced, and about one in ten draws is plain noise.
	task automatic send_random_frame();
		logic [7:0] frame [8];
		int         kind;
		int         spot;
		int         noise_len;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			noise_len = $urandom_range(4, 1);
			for (int i = 0; i < noise_len; i++) begin
				send_byte(8'($urandom_range(255)));
			end
			return;
		end
		frame[0] = FRAME_START;
		for (int i = 1; i < 7; i++) begin
			frame[i] = digit_char(4'($urandom_range(15)), 1'($urandom_range(1)));
		end
		frame[7] = FRAME_END;
		if (kind >= 74) begin
			spot = $urandom_range(7);
			frame[spot] = $urandom_range(1) ? near_miss($urandom_range(9))
				: 8'($urandom_range(255));
		end
		for (int i = 0; i < 8; i++) begin
			send_byte(frame[i]);
		end
	endtask

	// Watchdog: ends a run that hangs, reporting the words still due.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d words still due.",
			cycle_count, sb.results_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb         = new();
		sent_count = 0;
		arst_n     = 1'b0;
		rx_valid   = 1'b0;
		rx_byte    = 8'h00;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A null byte where the '#' belongs is a format error at position zero.
		send_byte(8'h00);
		// Digit extremes in both cases.
		send_text("#09afAF");
		send_byte(FRAME_END);
		// A '#' that arrives in mid-frame drops the frame.
		send_text("##");
		// Full-scale colour on all three channels.
		send_text("#FFFFFF");
		send_byte(FRAME_END);
		// The last position wants a carriage return; 0xFF must leave the
		// displayed colour untouched.
		send_text("#000000");
		send_byte(8'hFF);

		while (sent_count < TOTAL_WORDS) begin
			send_random_frame();
		end
		rx_valid <= 1'b0;

		while (sb.results_due.size() != 0) begin
			@(posedge clk);
		end
		// Anything the parser emits after this point has no prediction.
		repeat (8) @(posedge clk);

		$display("Sent %0d words in %0d cycles; checked %0d results.",
			sent_count, cycle_count, sb.words_checked);
		$display("Colours loaded: %0d, frames dropped for bad format: %0d.",
			sb.colours_loaded, sb.frames_dropped);
		if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
